>>> design/msts_pkg.sv
package msts_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] FLIGHT_MAX = 5'd31;
  localparam logic [CNT_W-1:0] MAX_FIRES  = 5'd16;

  // operations
  localparam logic [3:0] OP_START    = 4'd0;
  localparam logic [3:0] OP_STOP     = 4'd1;
  localparam logic [3:0] OP_ARM_ONCE = 4'd2;
  localparam logic [3:0] OP_ARM_PER  = 4'd3;
  localparam logic [3:0] OP_CANCEL   = 4'd4;
  localparam logic [3:0] OP_TICK     = 4'd5;
  localparam logic [3:0] OP_RUN_BEG  = 4'd6;
  localparam logic [3:0] OP_RUN_END  = 4'd7;
  localparam logic [3:0] OP_POST_REJ = 4'd8;

  // result kinds
  localparam logic [1:0] RK_ACK   = 2'd0;
  localparam logic [1:0] RK_FIRED = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NOT_RUN    = 3'd1;
  localparam logic [2:0] STS_BAD_INTV   = 3'd2;
  localparam logic [2:0] STS_NO_SLOT    = 3'd3;
  localparam logic [2:0] STS_STARTED    = 3'd4;
  localparam logic [2:0] STS_CANCEL_ERR = 3'd5;

  // slot states
  localparam logic [2:0] SS_FREE      = 3'd0;
  localparam logic [2:0] SS_PENDING   = 3'd1;
  localparam logic [2:0] SS_SUBMITTED = 3'd2;
  localparam logic [2:0] SS_EXECUTING = 3'd3;
  localparam logic [2:0] SS_CANCELLED = 3'd4;

  // scheduler run states
  localparam logic [1:0] RS_CREATED  = 2'd0;
  localparam logic [1:0] RS_RUNNING  = 2'd1;
  localparam logic [1:0] RS_STOPPING = 2'd2;
  localparam logic [1:0] RS_STOPPED  = 2'd3;

endpackage

>>> design/multi_slot_timer_scheduler.sv
// Timer-slot scheduler over 16 slots. Each word in carries an operation
// (start, stop, arm once, arm periodic, cancel, tick, run begin, run end,
// post rejected); each answers one or more result words, the final one
// flagged by last_o. Non-tick operations are resolved in the accept cycle
// and their single result lands in the output register. A tick while running
// walks the slot table with one shared compare unit, one slot per cycle,
// and each walk ends in a decision state that can wait on a stalled output.
// One walk is run per fired timer plus a final empty walk (skipped when the
// fire limit or the flight limit is reached), and when any timer fired a
// flush state then sends the final fired word.
// The first walk of a tick also frees due cancelled slots the executor no
// longer holds. Time and expiries saturate at all-ones.
// in_ready_o is low while a tick is being worked through.
module multi_slot_timer_scheduler
  import msts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] duration_i,
  input  logic [3:0]  timer_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  status_o,
  output logic [3:0]  timer_id_res_o,
  output logic [4:0]  in_flight_count_o,
  output logic [1:0]  run_state_o,
  output logic        last_o
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_SCAN  = 2'd1;
  localparam logic [1:0] F_DONE  = 2'd2;
  localparam logic [1:0] F_FLUSH = 2'd3;

  // slot table
  logic [2:0]           stat_q [SLOTS];
  logic [2:0]           stat_d [SLOTS];
  logic [SLOTS-1:0]     held_q, held_d;
  logic [TIME_BITS-1:0] expiry_q   [SLOTS];
  logic [TIME_BITS-1:0] interval_q [SLOTS];
  logic [SLOTS-1:0]     periodic_q;

  logic [TIME_BITS-1:0] now_q, now_d;
  logic [1:0]           sched_q, sched_d;
  logic [CNT_W-1:0]     flight_q, flight_d;

  // sequencer
  logic [1:0]           fsm_q, fsm_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic                 first_q, first_d;
  logic                 found_q, found_d;
  logic [SLOT_W-1:0]    best_q, best_d;
  logic [TIME_BITS-1:0] best_exp_q, best_exp_d;
  logic [CNT_W-1:0]     fires_q, fires_d;
  logic                 have_prev_q, have_prev_d;
  logic [SLOT_W-1:0]    prev_id_q, prev_id_d;
  logic [CNT_W-1:0]     prev_flt_q, prev_flt_d;

  // expiry / interval write port
  logic                 exp_we, arm_we;
  logic [SLOT_W-1:0]    wr_idx;
  logic [TIME_BITS-1:0] wr_exp, wr_intv;
  logic                 wr_per;

  // output register
  logic       out_valid_q, out_load, out_free;
  logic [1:0] o_kind_q, o_kind_d;
  logic [2:0] o_sts_q, o_sts_d;
  logic [3:0] o_id_q, o_id_d;
  logic [4:0] o_flt_q, o_flt_d;
  logic [1:0] o_rs_q, o_rs_d;
  logic       o_last_q, o_last_d;

  logic                 in_fire;
  logic [TIME_BITS-1:0] add_b, add_sum, dur_t;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic                 id_valid;
  logic [SLOT_W-1:0]    s;
  logic                 periodic_op;
  logic                 due;
  logic [TIME_BITS-1:0] cur_exp;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (fsm_q == F_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign dur_t       = TIME_BITS'(duration_i);
  assign id_valid    = ({1'b0, timer_id_i} < 5'(SLOTS));
  assign s           = timer_id_i[SLOT_W-1:0];
  assign periodic_op = (operation_i == OP_ARM_PER);

  // shared saturating adder: arm, tick advance, periodic rearm
  always_comb begin
    case (operation_i)
      OP_TICK:    add_b = TIME_BITS'(1);
      OP_RUN_END: add_b = interval_q[s];
      default:    add_b = dur_t;
    endcase
  end

  msts_sat_add u_add (
    .a_i   (now_q),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (stat_q[i] == SS_FREE) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // scan compare unit
  assign cur_exp = expiry_q[idx_q];
  assign due     = (cur_exp <= now_q);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) stat_d[i] = stat_q[i];
    held_d      = held_q;
    now_d       = now_q;
    sched_d     = sched_q;
    flight_d    = flight_q;
    fsm_d       = fsm_q;
    idx_d       = idx_q;
    first_d     = first_q;
    found_d     = found_q;
    best_d      = best_q;
    best_exp_d  = best_exp_q;
    fires_d     = fires_q;
    have_prev_d = have_prev_q;
    prev_id_d   = prev_id_q;
    prev_flt_d  = prev_flt_q;
    exp_we      = 1'b0;
    arm_we      = 1'b0;
    wr_idx      = s;
    wr_exp      = add_sum;
    wr_intv     = dur_t;
    wr_per      = periodic_op;
    out_load    = 1'b0;
    o_kind_d    = RK_ACK;
    o_sts_d     = STS_OK;
    o_id_d      = '0;
    o_flt_d     = flight_q;
    o_rs_d      = sched_q;
    o_last_d    = 1'b1;

    case (fsm_q)
      F_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (operation_i)
            OP_START: begin
              if (sched_q == RS_CREATED) begin
                sched_d = RS_RUNNING;
              end else begin
                o_kind_d = RK_ERROR;
                o_sts_d  = STS_STARTED;
              end
            end
            OP_STOP: begin
              if (sched_q == RS_CREATED) begin
                sched_d = RS_STOPPED;
              end else if (sched_q == RS_RUNNING) begin
                sched_d = RS_STOPPING;
                for (int i = 0; i < SLOTS; i++)
                  if (stat_q[i] == SS_PENDING) stat_d[i] = SS_CANCELLED;
              end
            end
            OP_ARM_ONCE, OP_ARM_PER: begin
              if (periodic_op && duration_i == '0) begin
                o_kind_d = RK_ERROR;
                o_sts_d  = STS_BAD_INTV;
              end else if (sched_q != RS_RUNNING) begin
                o_kind_d = RK_ERROR;
                o_sts_d  = STS_NOT_RUN;
              end else if (!free_found) begin
                o_kind_d = RK_ERROR;
                o_sts_d  = STS_NO_SLOT;
              end else begin
                stat_d[free_idx] = SS_PENDING;
                held_d[free_idx] = 1'b0;
                exp_we   = 1'b1;
                arm_we   = 1'b1;
                wr_idx   = free_idx;
                wr_intv  = periodic_op ? dur_t : '0;
                o_id_d   = 4'(free_idx);
              end
            end
            OP_CANCEL: begin
              o_id_d = timer_id_i;
              if (!id_valid || stat_q[s] == SS_FREE || stat_q[s] == SS_CANCELLED) begin
                o_kind_d = RK_ERROR;
                o_sts_d  = STS_CANCEL_ERR;
              end else begin
                stat_d[s] = SS_CANCELLED;
              end
            end
            OP_TICK: begin
              now_d = add_sum;
              if (sched_q == RS_RUNNING) begin
                out_load    = 1'b0;
                fsm_d       = F_SCAN;
                idx_d       = '0;
                first_d     = 1'b1;
                found_d     = 1'b0;
                fires_d     = '0;
                have_prev_d = 1'b0;
              end
            end
            OP_RUN_BEG: begin
              o_id_d = timer_id_i;
              if (id_valid && held_q[s]) begin
                if (stat_q[s] == SS_SUBMITTED) begin
                  stat_d[s] = SS_EXECUTING;
                end else if (stat_q[s] == SS_CANCELLED) begin
                  stat_d[s] = SS_FREE;
                  held_d[s] = 1'b0;
                  if (flight_q != '0) flight_d = flight_q - 1'b1;
                end
              end
            end
            OP_RUN_END: begin
              o_id_d = timer_id_i;
              if (id_valid && held_q[s]) begin
                held_d[s] = 1'b0;
                if (flight_q != '0) flight_d = flight_q - 1'b1;
                if (stat_q[s] == SS_EXECUTING && periodic_q[s] && sched_q == RS_RUNNING) begin
                  stat_d[s] = SS_PENDING;
                  exp_we    = 1'b1;
                end else begin
                  stat_d[s] = SS_FREE;
                end
              end
            end
            OP_POST_REJ: begin
              o_id_d = timer_id_i;
              if (id_valid && held_q[s]) begin
                stat_d[s] = SS_FREE;
                held_d[s] = 1'b0;
                if (flight_q != '0) flight_d = flight_q - 1'b1;
              end
            end
            default: ;
          endcase
          // drained stop: clear the table
          if (sched_d == RS_STOPPING && flight_d == '0) begin
            sched_d = RS_STOPPED;
            for (int i = 0; i < SLOTS; i++) stat_d[i] = SS_FREE;
            held_d = '0;
          end
          if (sched_q != RS_STOPPING && sched_d == RS_STOPPED && operation_i == OP_STOP &&
              flight_q == '0) begin
            for (int i = 0; i < SLOTS; i++) stat_d[i] = SS_FREE;
            held_d = '0;
          end
          if (operation_i == OP_STOP && flight_q == '0) begin
            sched_d = RS_STOPPED;
            for (int i = 0; i < SLOTS; i++) stat_d[i] = SS_FREE;
            held_d = '0;
          end
          o_flt_d = flight_d;
          o_rs_d  = sched_d;
        end
      end

      F_SCAN: begin
        if (first_q && stat_q[idx_q] == SS_CANCELLED && !held_q[idx_q] && due)
          stat_d[idx_q] = SS_FREE;
        if (stat_q[idx_q] == SS_PENDING && due && (!found_q || cur_exp < best_exp_q)) begin
          found_d    = 1'b1;
          best_d     = idx_q;
          best_exp_d = cur_exp;
        end
        if (idx_q == SLOT_W'(SLOTS - 1)) begin
          fsm_d   = F_DONE;
          first_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      F_DONE: begin
        if (found_q && flight_q != FLIGHT_MAX) begin
          if (!have_prev_q || out_free) begin
            if (have_prev_q) begin
              out_load = 1'b1;
              o_kind_d = RK_FIRED;
              o_id_d   = 4'(prev_id_q);
              o_flt_d  = prev_flt_q;
              o_last_d = 1'b0;
            end
            stat_d[best_q] = SS_SUBMITTED;
            held_d[best_q] = 1'b1;
            flight_d    = flight_q + 1'b1;
            fires_d     = fires_q + 1'b1;
            have_prev_d = 1'b1;
            prev_id_d   = best_q;
            prev_flt_d  = flight_q + 1'b1;
            if (fires_d == MAX_FIRES || flight_d == FLIGHT_MAX) begin
              fsm_d = F_FLUSH;
            end else begin
              fsm_d   = F_SCAN;
              idx_d   = '0;
              found_d = 1'b0;
            end
          end
        end else if (have_prev_q) begin
          fsm_d = F_FLUSH;
        end else if (out_free) begin
          out_load = 1'b1;
          fsm_d    = F_IDLE;
        end
      end

      F_FLUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_kind_d    = RK_FIRED;
          o_id_d      = 4'(prev_id_q);
          o_flt_d     = prev_flt_q;
          have_prev_d = 1'b0;
          fsm_d       = F_IDLE;
        end
      end

      default: fsm_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) stat_q[i] <= SS_FREE;
      held_q      <= '0;
      now_q       <= '0;
      sched_q     <= RS_CREATED;
      flight_q    <= '0;
      fsm_q       <= F_IDLE;
      idx_q       <= '0;
      first_q     <= 1'b0;
      found_q     <= 1'b0;
      fires_q     <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) stat_q[i] <= stat_d[i];
      held_q      <= held_d;
      now_q       <= now_d;
      sched_q     <= sched_d;
      flight_q    <= flight_d;
      fsm_q       <= fsm_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      found_q     <= found_d;
      fires_q     <= fires_d;
      have_prev_q <= have_prev_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_exp_q <= best_exp_d;
    prev_id_q  <= prev_id_d;
    prev_flt_q <= prev_flt_d;
    if (exp_we) expiry_q[wr_idx] <= wr_exp;
    if (arm_we) begin
      interval_q[wr_idx] <= wr_intv;
      periodic_q[wr_idx] <= wr_per;
    end
    if (out_load) begin
      o_kind_q <= o_kind_d;
      o_sts_q  <= o_sts_d;
      o_id_q   <= o_id_d;
      o_flt_q  <= o_flt_d;
      o_rs_q   <= o_rs_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = o_kind_q;
  assign status_o          = o_sts_q;
  assign timer_id_res_o    = o_id_q;
  assign in_flight_count_o = o_flt_q;
  assign run_state_o       = o_rs_q;
  assign last_o            = o_last_q;

endmodule

>>> design/msts_sat_add.sv
module msts_sat_add
  import msts_pkg::*;
(
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  output logic [TIME_BITS-1:0] sum_o
);

  logic [TIME_BITS:0] full;

  assign full  = {1'b0, a_i} + {1'b0, b_i};
  // clamp at the top of the time range
  assign sum_o = full[TIME_BITS] ? {TIME_BITS{1'b1}} : full[TIME_BITS-1:0];

endmodule

>>> design/msts_checker.sv
module msts_checker
  import msts_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] result_kind_o,
  input logic [2:0] status_o,
  input logic [3:0] timer_id_res_o,
  input logic       last_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(timer_id_res_o) &&
    $stable(result_kind_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // fired words always carry ok
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_FIRED |-> status_o == STS_OK)
    else $error("fired word with error status");

  // error words never carry ok
  a_err_sts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_ERROR |-> status_o != STS_OK)
    else $error("error word with ok status");

  // errors and acknowledges end their item
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RK_FIRED |-> last_o)
    else $error("non-fired word not marked last");

endmodule

bind multi_slot_timer_scheduler msts_checker u_msts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .status_o       (status_o),
  .timer_id_res_o (timer_id_res_o),
  .last_o         (last_o)
);

>>> dv/multi_slot_timer_scheduler_tb.sv
`timescale 1ns / 1ps

// Timer scheduler testbench. A behavioral copy of the scheduler predicts the
// result words of every accepted input word; a checker compares each output
// word field by field against the oldest predicted word.
module multi_slot_timer_scheduler_tb;
  import msts_pkg::*;

  // one predicted / observed result word
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] sts;
    logic [3:0] id;
    logic [4:0] flight;
    logic [1:0] rs;
    logic       lst;
  } res_word_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [TIME_BITS-1:0] TIME_SAT = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  operation_i = OP_START;
  logic [31:0] duration_i = '0;
  logic [3:0]  timer_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [2:0]  status_o;
  logic [3:0]  timer_id_res_o;
  logic [4:0]  in_flight_count_o;
  logic [1:0]  run_state_o;
  logic        last_o;

  always #5 clk_i = ~clk_i;

  multi_slot_timer_scheduler u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .duration_i,
    .timer_id_i, .out_valid_o, .out_ready_i, .result_kind_o, .status_o,
    .timer_id_res_o, .in_flight_count_o, .run_state_o, .last_o
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow state
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] now_q;
  logic [2:0]           slot_st [SLOTS];
  logic [TIME_BITS-1:0] slot_exp [SLOTS];
  logic [TIME_BITS-1:0] slot_intv [SLOTS];
  logic                 slot_per [SLOTS];
  logic                 slot_held [SLOTS];
  logic [1:0]           sched_rs;
  logic [4:0]           flights;

  res_word_t expected_words[$];
  int errors = 0;
  int stall_cnt = 0;
  bit hold_off = 1'b0;   // long receiver hold-off in progress
  bit hold_req = 1'b0;   // asks the hold-off process for one long stretch
  bit draining = 1'b0;   // no more stimulus, keep watchdog honest

  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_SAT : s[TIME_BITS-1:0];
  endfunction

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i] = SS_FREE; slot_exp[i] = '0; slot_intv[i] = '0;
      slot_per[i] = 1'b0; slot_held[i] = 1'b0;
    end
  endtask

  task automatic free_held(int s);
    slot_st[s] = SS_FREE;
    slot_held[s] = 1'b0;
    if (flights != 0) flights--;
  endtask

  // Applies one input word to the shadow state and queues its result words.
  task automatic predict_results(logic [3:0] op, logic [31:0] dur, logic [3:0] tid);
    res_word_t w[$];
    res_word_t r;
    int best;
    w = {};
    r = '0;
    case (op)
      OP_START: begin
        if (sched_rs == RS_CREATED) begin
          sched_rs = RS_RUNNING;
          r.kind = RK_ACK; r.sts = STS_OK;
        end else begin
          r.kind = RK_ERROR; r.sts = STS_STARTED;
        end
        r.flight = flights; w = {w, r};
      end
      OP_STOP: begin
        if (sched_rs == RS_CREATED) sched_rs = RS_STOPPED;
        else if (sched_rs == RS_RUNNING) begin
          sched_rs = RS_STOPPING;
          for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] == SS_PENDING) slot_st[i] = SS_CANCELLED;
        end
        if (flights == 0) begin
          clear_table(); sched_rs = RS_STOPPED;
        end
        r.flight = flights; w = {w, r};
      end
      OP_ARM_ONCE, OP_ARM_PER: begin
        r.kind = RK_ERROR;
        if (op == OP_ARM_PER && dur == 0) r.sts = STS_BAD_INTV;
        else if (sched_rs != RS_RUNNING) r.sts = STS_NOT_RUN;
        else begin
          r.sts = STS_NO_SLOT;
          for (int i = 0; i < SLOTS; i++)
            if (r.sts == STS_NO_SLOT && slot_st[i] == SS_FREE) begin
              slot_st[i] = SS_PENDING;
              slot_exp[i] = sat_add(now_q, dur);
              slot_intv[i] = (op == OP_ARM_PER) ? dur : '0;
              slot_per[i] = (op == OP_ARM_PER);
              slot_held[i] = 1'b0;
              r.kind = RK_ACK; r.sts = STS_OK; r.id = i[3:0];
            end
        end
        r.flight = flights; w = {w, r};
      end
      OP_CANCEL: begin
        r.id = tid;
        if (slot_st[tid] == SS_FREE || slot_st[tid] == SS_CANCELLED) begin
          r.kind = RK_ERROR; r.sts = STS_CANCEL_ERR;
        end else slot_st[tid] = SS_CANCELLED;
        r.flight = flights; w = {w, r};
      end
      OP_TICK: begin
        now_q = sat_add(now_q, 1);
        if (sched_rs == RS_RUNNING) begin
          // lazy reclaim of due cancelled slots no longer held
          for (int i = 0; i < SLOTS; i++)
            if (slot_st[i] == SS_CANCELLED && !slot_held[i] && slot_exp[i] <= now_q)
              slot_st[i] = SS_FREE;
          while (w.size() < MAX_FIRES && flights < FLIGHT_MAX) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (slot_st[i] == SS_PENDING && slot_exp[i] <= now_q &&
                  (best < 0 || slot_exp[i] < slot_exp[best]))
                best = i;
            if (best < 0) break;
            slot_st[best] = SS_SUBMITTED;
            slot_held[best] = 1'b1;
            flights++;
            r = '0; r.kind = RK_FIRED; r.id = best[3:0]; r.flight = flights;
            w = {w, r};
          end
        end
      end
      OP_RUN_BEG: begin
        if (slot_held[tid]) begin
          if (slot_st[tid] == SS_SUBMITTED) slot_st[tid] = SS_EXECUTING;
          else if (slot_st[tid] == SS_CANCELLED) free_held(tid);
        end
        r.id = tid; r.flight = flights; w = {w, r};
      end
      OP_RUN_END: begin
        if (slot_held[tid]) begin
          if (slot_st[tid] == SS_EXECUTING && slot_per[tid] && sched_rs == RS_RUNNING) begin
            // periodic rearm
            slot_st[tid] = SS_PENDING;
            slot_exp[tid] = sat_add(now_q, slot_intv[tid]);
            slot_held[tid] = 1'b0;
            if (flights != 0) flights--;
          end else free_held(tid);
        end
        r.id = tid; r.flight = flights; w = {w, r};
      end
      OP_POST_REJ: begin
        if (slot_held[tid]) free_held(tid);
        r.id = tid; r.flight = flights; w = {w, r};
      end
      default: begin
        r.flight = flights; w = {w, r};
      end
    endcase
    if (sched_rs == RS_STOPPING && flights == 0) begin
      clear_table(); sched_rs = RS_STOPPED;
    end
    if (w.size() == 0) begin
      r = '0; r.flight = flights; w = {w, r};
    end
    foreach (w[k]) begin
      w[k].rs = sched_rs;
      w[k].lst = (k == w.size() - 1);
      expected_words = {expected_words, w[k]};
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts with random gaps; valid drops only at the start of a gap
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_word(logic [3:0] op, logic [31:0] dur, logic [3:0] tid);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op; duration_i <= dur; timer_id_i <= tid;
    do @(posedge clk_i); while (!in_ready_o);
    predict_results(op, dur, tid);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus the long hold-off
  // ---------------------------------------------------------------------------
  int rx_phase = 0;
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (hold_off) out_ready_i <= 1'b0;
    else if (rx_phase[8]) out_ready_i <= 1'b1;   // stall-free stretch
    else out_ready_i <= ($urandom_range(0, 9) < 7);
  end

  // long hold-off, counted here in cycles
  always begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_word_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("unexpected result word kind %0d id %0d", result_kind_o, timer_id_res_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (result_kind_o !== exp_w.kind) report_mismatch("kind", result_kind_o, exp_w.kind);
        if (status_o !== exp_w.sts) report_mismatch("status", status_o, exp_w.sts);
        if (timer_id_res_o !== exp_w.id) report_mismatch("timer id", timer_id_res_o, exp_w.id);
        if (in_flight_count_o !== exp_w.flight)
          report_mismatch("in flight", in_flight_count_o, exp_w.flight);
        if (run_state_o !== exp_w.rs) report_mismatch("run state", run_state_o, exp_w.rs);
        if (last_o !== exp_w.lst) report_mismatch("last", last_o, exp_w.lst);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      stall_cnt <= 0;
    else if (in_valid_i || expected_words.size() != 0 || draining)
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic wait_empty();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Fresh lifecycle: stop down to stopped has no way back, so rerun after reset
  // is not allowed; instead each test works within the one running phase.
  task automatic test_directed();
    send_word(OP_TICK, '0, '0);            // tick while created
    send_word(OP_ARM_ONCE, 32'd3, '0);     // not running
    send_word(OP_ARM_PER, '0, '0);         // bad interval before not running
    send_word(OP_START, '0, '0);
    send_word(OP_START, '0, '0);           // already started
    send_word(OP_CANCEL, '0, 4'd15);       // cancel free slot
    send_word(OP_ARM_ONCE, 32'd0, '0);     // due on next tick
    send_word(OP_ARM_PER, 32'd2, '0);
    send_word(OP_ARM_ONCE, 32'hFFFF_FFFF, '0);  // saturated expiry
    send_word(OP_ARM_ONCE, 32'd5, '0);
    send_word(OP_CANCEL, '0, 4'd3);
    send_word(OP_CANCEL, '0, 4'd3);        // already cancelled
    send_word(OP_TICK, '0, '0);
    send_word(OP_RUN_BEG, '0, 4'd0);
    send_word(OP_RUN_END, '0, 4'd0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_RUN_BEG, '0, 4'd1);
    send_word(OP_RUN_END, '0, 4'd1);       // periodic rearm
    send_word(OP_POST_REJ, '0, 4'd1);      // not held: ignored
    send_word(OP_RUN_END, '0, 4'd9);       // not held: ignored
    send_word(4'd15, '0, 4'd7);            // unknown operation
  endtask

  // mostly well-formed timer lifecycles with random content
  task automatic test_random(int n);
    logic [3:0]  op;
    logic [31:0] dur;
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      dur = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 6));
      if (sel < 20) op = OP_ARM_ONCE;
      else if (sel < 32) op = OP_ARM_PER;
      else if (sel < 55) op = OP_TICK;
      else if (sel < 68) op = OP_RUN_BEG;
      else if (sel < 82) op = OP_RUN_END;
      else if (sel < 88) op = OP_POST_REJ;
      else if (sel < 95) op = OP_CANCEL;
      else op = 4'($urandom_range(9, 15));   // noise: unused operation codes
      if (sel == 99) op = OP_START;
      send_word(op, dur, 4'($urandom_range(0, 15)));
    end
  endtask

  // many due timers, receiver holds off long: the block backs up
  task automatic test_backpressure();
    for (int i = 0; i < 16; i++) send_word(OP_ARM_ONCE, 32'd1, '0);
    hold_req = 1'b1;
    send_word(OP_TICK, '0, '0);
    send_word(OP_TICK, '0, '0);
    for (int i = 0; i < 16; i++) send_word(OP_POST_REJ, '0, 4'(i));
  endtask

  task automatic test_stop();
    send_word(OP_ARM_ONCE, 32'd0, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_ARM_ONCE, 32'd4, '0);
    send_word(OP_STOP, '0, '0);            // stopping while in flight
    send_word(OP_STOP, '0, '0);
    send_word(OP_START, '0, '0);
    send_word(OP_ARM_ONCE, 32'd1, '0);
    for (int i = 0; i < 16; i++) send_word(OP_RUN_END, '0, 4'(i));
    send_word(OP_TICK, '0, '0);
  endtask

  initial begin
    now_q = '0; clear_table(); sched_rs = RS_CREATED; flights = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(220);
    test_backpressure();
    test_random(180);
    test_stop();
    in_valid_i <= 1'b0;
    draining = 1'b1;
    wait_empty();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/msts_pkg.sv
design/msts_sat_add.sv
design/multi_slot_timer_scheduler.sv
design/msts_checker.sv
dv/multi_slot_timer_scheduler_tb.sv
